/* hw/rtl/grdc_pkg.sv */
// Shared types, codes and default constants of the grid ray caster.
package grdc_pkg;

    // Default geometry of the grid, the screen and the texture.
    localparam int GRID_SIDE_DEF   = 64;
    localparam int SCREEN_ROWS_DEF = 512;
    localparam int TEX_SIDE_DEF    = 64;

    // Register and payload widths.
    localparam int STEPS_W      = 13;
    localparam logic [STEPS_W-1:0] MAX_STEPS_RST = 13'd128;
    localparam int IN_DATA_W    = 160;
    localparam int OUT_DATA_W   = 80;

    // Request kinds carried on the input tuser bit.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    // Face codes of the result.
    localparam logic [1:0] COMPASS_NORTH = 2'd0;
    localparam logic [1:0] COMPASS_SOUTH = 2'd1;
    localparam logic [1:0] COMPASS_WEST  = 2'd2;
    localparam logic [1:0] COMPASS_EAST  = 2'd3;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_INIT,
        ST_STEP,
        ST_CHECK,
        ST_PERP,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic take;
        logic setup;
        logic init;
        logic step;
        logic mark_hit;
        logic perp;
        logic div_load;
        logic div_step;
        logic emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic steps_out;
        logic wall;
        logic div_last;
        logic out_free;
    } ctl_stat_t;

endpackage

/* hw/rtl/grdc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module grdc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/grdc_ctrl.sv */
// Controller state machine of the grid ray caster.
module grdc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    input  grdc_pkg::ctl_stat_t stat,
    output grdc_pkg::ctl_cmd_t  cmd
);

    grdc_pkg::state_t state_reg;
    grdc_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grdc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            grdc_pkg::ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = grdc_pkg::ST_IDLE;
                end
            end
            grdc_pkg::ST_IDLE:
            begin
                if (s_tvalid && s_tuser == grdc_pkg::MODE_CAST)
                begin
                    state_next = grdc_pkg::ST_SETUP;
                end
            end
            grdc_pkg::ST_SETUP:
            begin
                state_next = grdc_pkg::ST_INIT;
            end
            grdc_pkg::ST_INIT:
            begin
                state_next = grdc_pkg::ST_STEP;
            end
            grdc_pkg::ST_STEP:
            begin
                state_next = stat.steps_out ? grdc_pkg::ST_DONE : grdc_pkg::ST_CHECK;
            end
            grdc_pkg::ST_CHECK:
            begin
                state_next = stat.wall ? grdc_pkg::ST_PERP : grdc_pkg::ST_STEP;
            end
            grdc_pkg::ST_PERP:
            begin
                state_next = grdc_pkg::ST_DIV_LOAD;
            end
            grdc_pkg::ST_DIV_LOAD:
            begin
                state_next = grdc_pkg::ST_DIV;
            end
            grdc_pkg::ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = grdc_pkg::ST_DONE;
                end
            end
            grdc_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = grdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = grdc_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            grdc_pkg::ST_CLEAR:    cmd.clear = 1'b1;
            grdc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            grdc_pkg::ST_SETUP:    cmd.setup = 1'b1;
            grdc_pkg::ST_INIT:     cmd.init = 1'b1;
            grdc_pkg::ST_STEP:     cmd.step = !stat.steps_out;
            grdc_pkg::ST_CHECK:    cmd.mark_hit = stat.wall;
            grdc_pkg::ST_PERP:     cmd.perp = 1'b1;
            grdc_pkg::ST_DIV_LOAD: cmd.div_load = 1'b1;
            grdc_pkg::ST_DIV:      cmd.div_step = 1'b1;
            grdc_pkg::ST_DONE:     cmd.emit = stat.out_free;
            default:               cmd = '0;
        endcase
    end

endmodule

/* hw/rtl/grdc_datapath.sv */
// Datapath of the grid ray caster: grid memory, DDA stepper, divider and result register.
module grdc_datapath #(
    parameter int GRID_SIDE   = grdc_pkg::GRID_SIDE_DEF,
    parameter int SCREEN_ROWS = grdc_pkg::SCREEN_ROWS_DEF,
    parameter int TEX_SIDE    = grdc_pkg::TEX_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [grdc_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  logic                                cfg_wr_en,
    input  logic [grdc_pkg::STEPS_W-1:0]        cfg_wr_data,
    output logic [grdc_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  grdc_pkg::ctl_cmd_t                  cmd,
    output grdc_pkg::ctl_stat_t                 stat
);

    localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
    localparam int AW        = $clog2(DEPTH);
    localparam int IW        = $clog2(GRID_SIDE);
    localparam int CW        = $clog2(((GRID_SIDE > 64) ? GRID_SIDE : 64) + 1) + 1;
    localparam int DVW       = $clog2(SCREEN_ROWS) + 17;
    localparam int DCW       = $clog2(DVW + 1);
    localparam int HALF_ROWS = SCREEN_ROWS / 2;
    localparam logic [DVW-1:0] DIVIDEND = DVW'(SCREEN_ROWS) << 16;
    localparam logic signed [CW-1:0] GRID_S = CW'(GRID_SIDE);

    // Input fields.
    logic [5:0]         in_cell_x;
    logic [5:0]         in_cell_y;
    logic               in_cell_wall;
    assign in_cell_x    = s_tdata[5:0];
    assign in_cell_y    = s_tdata[11:6];
    assign in_cell_wall = s_tdata[12];

    // Request registers of a ray.
    logic [21:0]        origin_x_reg;
    logic [21:0]        origin_y_reg;
    logic signed [17:0] dir_x_reg;
    logic signed [17:0] dir_y_reg;
    logic [31:0]        delta_x_reg;
    logic [31:0]        delta_y_reg;
    logic [grdc_pkg::STEPS_W-1:0] max_steps_reg;

    // Working registers.
    logic [48:0]          px_reg;
    logic [48:0]          py_reg;
    logic [31:0]          sdx_reg;
    logic [31:0]          sdy_reg;
    logic signed [CW-1:0] mx_reg;
    logic signed [CW-1:0] my_reg;
    logic                 side_reg;
    logic                 inrange_reg;
    logic                 hit_reg;
    logic [grdc_pkg::STEPS_W-1:0] n_reg;
    logic [31:0]          perp_reg;
    logic [31:0]          prod_reg;
    logic [31:0]          divisor_reg;
    logic [31:0]          rem_reg;
    logic [DVW-1:0]       q_reg;
    logic [DCW-1:0]       div_cnt_reg;
    logic [AW-1:0]        clr_addr_reg;

    // Result register.
    logic [grdc_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                            out_hit_reg;
    logic                            out_valid_reg;

    // Memory port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    logic dx_neg;
    logic dy_neg;
    assign dx_neg = dir_x_reg[17];
    assign dy_neg = dir_y_reg[17];

    // Grid writes come from the clearing pass or from a write request.
    always_comb
    begin
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = 1'b0;
        end
        else
        begin
            ram_we    = cmd.take && (s_tuser == grdc_pkg::MODE_WRITE)
                        && (32'(in_cell_x) < 32'(GRID_SIDE))
                        && (32'(in_cell_y) < 32'(GRID_SIDE));
            ram_waddr = AW'(32'(in_cell_y) * 32'(GRID_SIDE) + 32'(in_cell_x));
            ram_wdata = in_cell_wall;
        end
    end

    grdc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // First crossing products: fraction or its complement times the delta.
    logic [16:0] fx_sel;
    logic [16:0] fy_sel;
    always_comb
    begin
        fx_sel = dx_neg ? {1'b0, origin_x_reg[15:0]} : 17'h10000 - {1'b0, origin_x_reg[15:0]};
        fy_sel = dy_neg ? {1'b0, origin_y_reg[15:0]} : 17'h10000 - {1'b0, origin_y_reg[15:0]};
    end

    // One DDA step: cross the nearer boundary, ties go to y.
    logic                 step_x;
    logic [32:0]          sum_x;
    logic [32:0]          sum_y;
    logic signed [CW-1:0] mx_n;
    logic signed [CW-1:0] my_n;
    logic                 inrange_n;
    always_comb
    begin
        step_x = sdx_reg < sdy_reg;
        sum_x  = {1'b0, sdx_reg} + {1'b0, delta_x_reg};
        sum_y  = {1'b0, sdy_reg} + {1'b0, delta_y_reg};
        mx_n   = mx_reg;
        my_n   = my_reg;
        if (step_x)
        begin
            mx_n = dx_neg ? mx_reg - CW'(1) : mx_reg + CW'(1);
        end
        else
        begin
            my_n = dy_neg ? my_reg - CW'(1) : my_reg + CW'(1);
        end
        inrange_n = (mx_n >= 0) && (mx_n < GRID_S) && (my_n >= 0) && (my_n < GRID_S);
        ram_raddr = AW'(32'(my_n[IW-1:0]) * 32'(GRID_SIDE) + 32'(mx_n[IW-1:0]));
    end

    // Perpendicular distance and the along-wall product.
    logic [31:0]        perp_n;
    logic signed [17:0] dir_sel;
    logic signed [50:0] prod_full;
    always_comb
    begin
        if (!side_reg)
        begin
            perp_n = (sdx_reg >= delta_x_reg) ? sdx_reg - delta_x_reg : 32'd0;
        end
        else
        begin
            perp_n = (sdy_reg >= delta_y_reg) ? sdy_reg - delta_y_reg : 32'd0;
        end
        dir_sel   = side_reg ? dir_x_reg : dir_y_reg;
        prod_full = $signed({1'b0, perp_reg}) * dir_sel;
    end

    // One restoring division step.
    logic [32:0] rem_sh;
    logic        rem_ge;
    always_comb
    begin
        rem_sh = {rem_reg, q_reg[DVW-1]};
        rem_ge = rem_sh >= {1'b0, divisor_reg};
    end

    // Final result fields.
    logic [DVW-2:0] half;
    logic [DVW-1:0] start_w;
    logic [DVW-1:0] end_sum;
    logic [DVW-1:0] end_w;
    logic [15:0]    frac;
    logic [31:0]    tex_prod;
    logic [15:0]    tex_raw;
    logic [15:0]    tex_w;
    logic [1:0]     compass;
    logic [grdc_pkg::OUT_DATA_W-1:0] result;
    always_comb
    begin
        half    = q_reg[DVW-1:1];
        start_w = ({1'b0, half} >= DVW'(HALF_ROWS)) ? DVW'(0) : DVW'(HALF_ROWS) - {1'b0, half};
        end_sum = {1'b0, half} + DVW'(HALF_ROWS);
        end_w   = (end_sum >= DVW'(SCREEN_ROWS)) ? DVW'(SCREEN_ROWS) : end_sum;
        if (!side_reg)
        begin
            compass = dx_neg ? grdc_pkg::COMPASS_WEST : grdc_pkg::COMPASS_EAST;
            frac    = origin_y_reg[15:0] + prod_reg[31:16];
        end
        else
        begin
            compass = (!dy_neg && dir_y_reg != 18'sd0) ? grdc_pkg::COMPASS_SOUTH
                                                       : grdc_pkg::COMPASS_NORTH;
            frac    = origin_x_reg[15:0] + prod_reg[31:16];
        end
        tex_prod = 32'(frac) * 32'(TEX_SIDE);
        tex_raw  = tex_prod[31:16];
        tex_w    = (compass == grdc_pkg::COMPASS_WEST || compass == grdc_pkg::COMPASS_SOUTH)
                   ? 16'(TEX_SIDE - 1) - tex_raw : tex_raw;
        result   = {7'd0, my_reg[5:0], mx_reg[5:0], tex_w[5:0], end_w[9:0], start_w[9:0],
                    perp_reg, compass, side_reg};
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_steps_reg <= grdc_pkg::MAX_STEPS_RST;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            n_reg         <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_steps_reg <= cfg_wr_data;
            end
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.init)
            begin
                hit_reg <= 1'b0;
                n_reg   <= '0;
            end
            else
            begin
                if (cmd.mark_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmd.step)
                begin
                    n_reg <= n_reg + grdc_pkg::STEPS_W'(1);
                end
            end
            if (cmd.div_load)
            begin
                div_cnt_reg <= DCW'(DVW);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            origin_x_reg <= s_tdata[34:13];
            origin_y_reg <= s_tdata[56:35];
            dir_x_reg    <= s_tdata[74:57];
            dir_y_reg    <= s_tdata[92:75];
            delta_x_reg  <= s_tdata[124:93];
            delta_y_reg  <= s_tdata[156:125];
        end
        if (cmd.setup)
        begin
            px_reg <= 49'(fx_sel) * 49'(delta_x_reg);
            py_reg <= 49'(fy_sel) * 49'(delta_y_reg);
        end
        if (cmd.init)
        begin
            sdx_reg  <= px_reg[48] ? 32'hFFFF_FFFF : px_reg[47:16];
            sdy_reg  <= py_reg[48] ? 32'hFFFF_FFFF : py_reg[47:16];
            mx_reg   <= CW'(origin_x_reg[21:16]);
            my_reg   <= CW'(origin_y_reg[21:16]);
            side_reg <= 1'b0;
        end
        if (cmd.step)
        begin
            if (step_x)
            begin
                sdx_reg <= sum_x[32] ? 32'hFFFF_FFFF : sum_x[31:0];
            end
            else
            begin
                sdy_reg <= sum_y[32] ? 32'hFFFF_FFFF : sum_y[31:0];
            end
            mx_reg      <= mx_n;
            my_reg      <= my_n;
            side_reg    <= !step_x;
            inrange_reg <= inrange_n;
        end
        if (cmd.perp)
        begin
            perp_reg <= perp_n;
        end
        if (cmd.div_load)
        begin
            divisor_reg <= (perp_reg == 32'd0) ? 32'd1 : perp_reg;
            rem_reg     <= '0;
            q_reg       <= DIVIDEND;
            prod_reg    <= prod_full[31:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? 32'(rem_sh - {1'b0, divisor_reg}) : rem_sh[31:0];
            q_reg   <= {q_reg[DVW-2:0], rem_ge};
        end
        if (cmd.emit)
        begin
            out_hit_reg  <= hit_reg;
            out_data_reg <= hit_reg ? result : '0;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        stat.clr_last  = clr_addr_reg == AW'(DEPTH - 1);
        stat.steps_out = n_reg >= max_steps_reg;
        stat.wall      = !inrange_reg || ram_rdata;
        stat.div_last  = div_cnt_reg == DCW'(1);
        stat.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tvalid = out_valid_reg;

    // A miss carries only zeros.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss result carries nonzero fields");

    // A step is never taken past the step budget.
    a_step_budget: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> n_reg < max_steps_reg)
        else $error("DDA step beyond max_steps");

    // The result register is loaded only when it is free.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg || m_tready)
        else $error("result overwritten before it was taken");

    // Division steps stay within the iteration count.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> div_cnt_reg != '0)
        else $error("division step after the last iteration");

endmodule

/* hw/rtl/grid_ray_dda_caster.sv */
// Top level of the grid ray caster: controller and datapath.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+---------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | grid write or ray cast request
//  m_*      | out       | m_tvalid/m_tready  | one result per ray cast request
//  cfg_*    | in        | cfg_wr_en          | max_steps register
//
// A grid write goes to the grid memory as it is accepted. A ray cast runs through setup,
// init, and a step and a check state per cell entered (the grid read is registered); on a
// wall hit, through perp, division load and the wall-height division, which takes one
// cycle per quotient bit. A ray that runs out of steps goes from a step state to done. The
// done state waits for a free output register before the next request can be taken. After
// reset all GRID_SIDE*GRID_SIDE cells of the grid memory are cleared, one cell per cycle,
// before the first request is taken. A finished result waits in the output register while
// the next request is accepted.
module grid_ray_dda_caster #(
    parameter int GRID_SIDE   = grdc_pkg::GRID_SIDE_DEF,
    parameter int SCREEN_ROWS = grdc_pkg::SCREEN_ROWS_DEF,
    parameter int TEX_SIDE    = grdc_pkg::TEX_SIDE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cell_x, cell_y, cell_wall, origin_x, origin_y, dir_x, dir_y, delta_x, delta_y
    input  logic [grdc_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // face_side, compass, perp_dist, draw_start, draw_end, tex_column, hit_cell_x, hit_cell_y
    output logic [grdc_pkg::OUT_DATA_W-1:0] m_tdata,
    // hit
    output logic                            m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [grdc_pkg::STEPS_W-1:0]    cfg_wr_data
);

    grdc_pkg::ctl_cmd_t  cmd;
    grdc_pkg::ctl_stat_t stat;

    // Sequencer.
    grdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Grid, stepper, divider and result register.
    grdc_datapath #(
        .GRID_SIDE   (GRID_SIDE),
        .SCREEN_ROWS (SCREEN_ROWS),
        .TEX_SIDE    (TEX_SIDE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
